### rtl/core/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/arpc_pkg.sv
package arpc_pkg;

    localparam int NUM_AXES_DEF     = 6;
    localparam int NUM_GAINS        = 6;
    localparam int ONE_Q16          = 65536;
    localparam int RANGE_MARGIN     = 3277;
    localparam int GUARD_MARGIN_LIN = 3277;
    localparam int GUARD_MARGIN_ANG = 9830;
    localparam int NUM_LIN_AXES     = 3;
    localparam int RAMP_SLOPE       = 20;
    localparam int GUARD_RESET      = 200;
    localparam int APB_AW           = 5;
    localparam int APB_DW           = 32;

    localparam logic [1:0] MODE_SETPOINT = 2'd0;
    localparam logic [1:0] MODE_RANGE    = 2'd1;

    typedef enum logic [2:0] {
        REG_CONTROL_MODE = 3'd0,
        REG_GUARD_CYCLES = 3'd1,
        REG_GAIN0        = 3'd2,
        REG_GAIN1        = 3'd3,
        REG_GAIN2        = 3'd4,
        REG_GAIN3        = 3'd5,
        REG_GAIN4        = 3'd6,
        REG_GAIN5        = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [15:0]                 guard;
        logic [NUM_GAINS-1:0][22:0]  gain;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         axis;
        logic signed [31:0] measured_value;
        logic               set_range;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic               range_active;
        logic               set_desired;
        logic signed [31:0] desired_command;
        logic               set_weight;
        logic [16:0]        weight_cmd;
    } t_item;

    typedef struct packed {
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic               active;
        logic signed [31:0] desired;
        logic [16:0]        weight;
    } t_axis_state;

    localparam t_axis_state STATE_RESET = '{
        low:     32'sd0,
        high:    32'sd0,
        active:  1'b0,
        desired: 32'(ONE_Q16),
        weight:  17'(ONE_Q16)
    };

    typedef struct packed {
        logic [2:0]         axis;
        logic signed [31:0] desired;
        logic [16:0]        weight;
    } t_res;

    typedef struct packed {
        logic               wr;
        t_axis_state        nxt;
        logic signed [34:0] diff;
        t_res               res;
    } t_law_res;

    typedef struct packed {
        logic signed [34:0] diff;
        logic [22:0]        gain;
        t_res               res;
    } t_vel_req;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/arpc_cfg.sv
module arpc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arpc_pkg::APB_AW-1:0]  paddr,
    input  logic [arpc_pkg::APB_DW-1:0]  pwdata,
    output logic [arpc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output arpc_pkg::t_cfg               o_cfg
);

    arpc_pkg::t_reg_idx idx;
    logic               wr;
    logic [1:0]         r_mode;
    logic [15:0]        r_guard;
    logic [arpc_pkg::NUM_GAINS-1:0][22:0] r_gain;

    assign idx   = arpc_pkg::t_reg_idx'(paddr[4:2]);
    assign wr    = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= arpc_pkg::MODE_SETPOINT;
            r_guard <= 16'(arpc_pkg::GUARD_RESET);
            for (int g = 0; g < arpc_pkg::NUM_GAINS; g++) begin
                r_gain[g] <= 23'(arpc_pkg::ONE_Q16);
            end
        end else if (wr) begin
            case (idx)
                arpc_pkg::REG_CONTROL_MODE: r_mode  <= pwdata[1:0];
                arpc_pkg::REG_GUARD_CYCLES: r_guard <= pwdata[15:0];
                arpc_pkg::REG_GAIN0,
                arpc_pkg::REG_GAIN1,
                arpc_pkg::REG_GAIN2,
                arpc_pkg::REG_GAIN3,
                arpc_pkg::REG_GAIN4,
                arpc_pkg::REG_GAIN5: begin
                    r_gain[3'(idx) - 3'(arpc_pkg::REG_GAIN0)] <= pwdata[22:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            arpc_pkg::REG_CONTROL_MODE: prdata = 32'(r_mode);
            arpc_pkg::REG_GUARD_CYCLES: prdata = 32'(r_guard);
            arpc_pkg::REG_GAIN0,
            arpc_pkg::REG_GAIN1,
            arpc_pkg::REG_GAIN2,
            arpc_pkg::REG_GAIN3,
            arpc_pkg::REG_GAIN4,
            arpc_pkg::REG_GAIN5: prdata = 32'(r_gain[3'(idx) - 3'(arpc_pkg::REG_GAIN0)]);
            default: prdata = '0;
        endcase
    end

    assign o_cfg.mode  = r_mode;
    assign o_cfg.guard = r_guard;
    assign o_cfg.gain  = r_gain;

endmodule

### rtl/core/arpc_mem.sv
module arpc_mem #(
    parameter int NUM_AXES = arpc_pkg::NUM_AXES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [((NUM_AXES > 1) ? $clog2(NUM_AXES) : 1)-1:0] i_rd_addr,
    output arpc_pkg::t_axis_state o_rd_data,
    input  logic                  i_wr_en,
    input  logic [((NUM_AXES > 1) ? $clog2(NUM_AXES) : 1)-1:0] i_wr_addr,
    input  arpc_pkg::t_axis_state i_wr_data
);

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    arpc_pkg::t_axis_state r_mem [NUM_AXES];
    arpc_pkg::t_axis_state r_rd_data;
    logic [AW-1:0]         r_rd_addr;
    logic [NUM_AXES-1:0]   r_vld;
    logic                  r_fwd_vld;
    logic [AW-1:0]         r_fwd_addr;
    arpc_pkg::t_axis_state r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // entry valid bits stand in for clearing the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
            r_fwd_vld        <= 1'b1;
        end
    end

    // last write, covers a read issued on the edge of that write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_rd_addr)) begin
            o_rd_data = r_fwd_data;
        end else if (r_vld[r_rd_addr]) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = arpc_pkg::STATE_RESET;
        end
    end

endmodule

### rtl/core/arpc_law.sv
module arpc_law (
    input  arpc_pkg::t_item       i_item,
    input  arpc_pkg::t_axis_state i_cur,
    input  logic [1:0]            i_mode,
    input  logic                  i_guard,
    input  logic                  i_in_range,
    output arpc_pkg::t_law_res    o_res
);

    arpc_pkg::t_axis_state st;
    logic signed [31:0]    value;
    logic signed [32:0]    width;
    logic                  narrow;
    logic signed [32:0]    ss;
    logic signed [33:0]    thi;
    logic signed [33:0]    tlo;
    logic signed [33:0]    v34;
    logic signed [39:0]    wl;
    logic signed [39:0]    wh;
    logic signed [39:0]    wmax;
    logic signed [34:0]    diff;
    logic signed [31:0]    margin;

    always_comb begin
        value = i_item.measured_value;
        v34   = 34'(value);

        // loads requested by the item
        st = i_cur;
        if (i_item.set_range) begin
            st.low    = i_item.range_low;
            st.high   = i_item.range_high;
            st.active = i_item.range_active;
        end
        if (i_item.set_desired) begin
            st.desired = i_item.desired_command;
        end
        if (i_item.set_weight) begin
            st.weight = (i_item.weight_cmd > 17'(arpc_pkg::ONE_Q16)) ?
                        17'(arpc_pkg::ONE_Q16) : i_item.weight_cmd;
        end

        // shrunk range
        width  = 33'(st.high) - 33'(st.low);
        narrow = width < 33'(2 * arpc_pkg::RANGE_MARGIN);
        ss     = narrow ? (width >>> 1) : 33'(arpc_pkg::RANGE_MARGIN);
        thi    = 34'(st.high) - 34'(ss);
        tlo    = 34'(st.low) + 34'(ss);

        // weight ramp inside the range
        wl   = (40'(value) - 40'(st.high)) * 40'(arpc_pkg::RAMP_SLOPE)
               + 40'(arpc_pkg::ONE_Q16);
        wh   = (40'(st.low) - 40'(value)) * 40'(arpc_pkg::RAMP_SLOPE)
               + 40'(arpc_pkg::ONE_Q16);
        wmax = (wl > wh) ? wl : wh;

        diff = 35'sd0;
        case (i_mode)
            arpc_pkg::MODE_SETPOINT: begin
                diff = 35'(st.desired) - 35'(value);
            end
            arpc_pkg::MODE_RANGE: begin
                if (st.active) begin
                    if (v34 > thi) begin
                        diff       = 35'(thi) - 35'(value);
                        st.desired = arpc_pkg::sat32(64'(thi));
                    end else if (v34 < tlo) begin
                        diff       = 35'(tlo) - 35'(value);
                        st.desired = arpc_pkg::sat32(64'(tlo));
                    end else begin
                        st.desired = value;
                    end
                    if ((value > st.high) || (value < st.low)) begin
                        st.weight = 17'(arpc_pkg::ONE_Q16);
                    end else if (wmax < 40'sd0) begin
                        st.weight = 17'd0;
                    end else begin
                        st.weight = wmax[16:0];
                    end
                end
            end
            default: begin
                diff = 35'sd0;
            end
        endcase

        // start-up hold
        margin = (i_item.axis < 3'(arpc_pkg::NUM_LIN_AXES)) ?
                 32'(arpc_pkg::GUARD_MARGIN_LIN) : 32'(arpc_pkg::GUARD_MARGIN_ANG);
        if (i_guard) begin
            st.desired = value;
            st.low     = arpc_pkg::sat32(64'(value) - 64'(margin));
            st.high    = arpc_pkg::sat32(64'(value) + 64'(margin));
            st.active  = 1'b1;
            diff       = 35'sd0;
        end

        o_res.wr       = i_in_range;
        o_res.nxt      = st;
        o_res.res.axis = i_item.axis;
        if (i_in_range) begin
            o_res.diff        = diff;
            o_res.res.desired = st.desired;
            o_res.res.weight  = st.weight;
        end else begin
            o_res.diff        = 35'sd0;
            o_res.res.desired = 32'sd0;
            o_res.res.weight  = 17'd0;
        end
    end

endmodule

### rtl/core/arpc_vel.sv
module arpc_vel (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  arpc_pkg::t_vel_req i_req,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_axis,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_desired,
    output logic [16:0]        o_weight
);

    logic               r_s2_vld;
    arpc_pkg::t_vel_req r_s2;
    logic               r_s3_vld;
    logic signed [58:0] r_prod;
    arpc_pkg::t_res     r_s3_res;
    logic               r_o_vld;
    logic signed [31:0] r_o_vel;
    arpc_pkg::t_res     r_o_res;
    logic               rdy_o;
    logic               rdy3;
    logic               rdy2;
    logic signed [23:0] gain_s;
    logic signed [58:0] prod;

    assign rdy_o   = !r_o_vld || !i_stall;
    assign rdy3    = !r_s3_vld || rdy_o;
    assign rdy2    = !r_s2_vld || rdy3;
    assign o_ready = rdy2;

    assign gain_s = signed'({1'b0, r_s2.gain});
    assign prod   = 59'(gain_s) * 59'(r_s2.diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (rdy2) begin
                r_s2_vld <= i_valid;
            end
            if (rdy3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (rdy_o) begin
                r_o_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_s2 <= i_req;
        end
        if (rdy3 && r_s2_vld) begin
            r_prod   <= prod;
            r_s3_res <= r_s2.res;
        end
        if (rdy_o && r_s3_vld) begin
            // floor of the Q16.16 product, then clamp
            r_o_vel <= arpc_pkg::sat32(64'(r_prod >>> 16));
            r_o_res <= r_s3_res;
        end
    end

    assign o_valid    = r_o_vld;
    assign o_axis     = r_o_res.axis;
    assign o_velocity = r_o_vel;
    assign o_desired  = r_o_res.desired;
    assign o_weight   = r_o_res.weight;

endmodule

### rtl/core/axis_range_position_controller.sv
// Per-axis setpoint and range position controller in Q16.16. Each request carries one axis
// sample with optional new range, desired value and weight; the axis state sits in one
// synchronous memory that is read when the request is taken and written back as it leaves the
// first stage, with a forwarding register so the same axis may arrive on consecutive cycles.
// One request is taken every clock cycle while o_in_stall is low; its result leaves the output
// register after state update, gain multiply and rounding with saturation. Entries read as their
// reset values through per-axis valid bits, so no clearing pass follows reset. Mode 0 drives
// gain*(desired-measured), mode 1 steers into the range shrunk by a margin and ramps the weight,
// modes 2 and 3 give zero. For the first guard_cycles full axis sweeps the velocity is zero and
// each range is re-centred at the measured value.
`include "assert_macros.svh"

module axis_range_position_controller #(
    parameter int NUM_AXES = arpc_pkg::NUM_AXES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arpc_pkg::APB_AW-1:0]  paddr,
    input  logic [arpc_pkg::APB_DW-1:0]  pwdata,
    output logic [arpc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_axis,
    input  logic signed [31:0]           i_measured_value,
    input  logic                         i_set_range,
    input  logic signed [31:0]           i_range_low,
    input  logic signed [31:0]           i_range_high,
    input  logic                         i_range_active,
    input  logic                         i_set_desired,
    input  logic signed [31:0]           i_desired_command,
    input  logic                         i_set_weight,
    input  logic [16:0]                  i_weight_cmd,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_out_axis,
    output logic signed [31:0]           o_velocity_command,
    output logic signed [31:0]           o_desired_out,
    output logic [16:0]                  o_weight_out
);

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    arpc_pkg::t_cfg        cfg;
    arpc_pkg::t_item       in_item;
    arpc_pkg::t_item       r_item;
    logic                  r_s1_vld;
    arpc_pkg::t_axis_state cur;
    arpc_pkg::t_law_res    law;
    arpc_pkg::t_vel_req    vreq;
    logic                  vel_rdy;
    logic                  rdy1;
    logic                  accept;
    logic                  s1_leave;
    logic                  in_range;
    logic                  last_axis;
    logic                  guard_on;
    logic                  mem_wr;
    logic [15:0]           r_start_cnt;
    logic [15:0]           n_start_cnt;
    logic [AW+2:0]         in_ax_ext;
    logic [AW+2:0]         s1_ax_ext;
    logic [2:0]            gsel;

    arpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        in_item.axis            = i_axis;
        in_item.measured_value  = i_measured_value;
        in_item.set_range       = i_set_range;
        in_item.range_low       = i_range_low;
        in_item.range_high      = i_range_high;
        in_item.range_active    = i_range_active;
        in_item.set_desired     = i_set_desired;
        in_item.desired_command = i_desired_command;
        in_item.set_weight      = i_set_weight;
        in_item.weight_cmd      = i_weight_cmd;
    end

    assign rdy1       = !r_s1_vld || vel_rdy;
    assign o_in_stall = !rdy1;
    assign accept     = i_in_valid && rdy1;
    assign s1_leave   = r_s1_vld && vel_rdy;

    assign in_ax_ext = (AW + 3)'(i_axis);
    assign s1_ax_ext = (AW + 3)'(r_item.axis);
    assign in_range  = 5'(r_item.axis) < 5'(NUM_AXES);
    assign last_axis = 5'(r_item.axis) == 5'(NUM_AXES - 1);
    assign guard_on  = r_start_cnt < cfg.guard;
    assign mem_wr    = s1_leave && law.wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (rdy1) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
        end
    end

    arpc_mem #(
        .NUM_AXES (NUM_AXES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (in_ax_ext[AW-1:0]),
        .o_rd_data (cur),
        .i_wr_en   (mem_wr),
        .i_wr_addr (s1_ax_ext[AW-1:0]),
        .i_wr_data (law.nxt)
    );

    arpc_law u_law (
        .i_item     (r_item),
        .i_cur      (cur),
        .i_mode     (cfg.mode),
        .i_guard    (guard_on),
        .i_in_range (in_range),
        .o_res      (law)
    );

    always_comb begin
        n_start_cnt = r_start_cnt;
        if (s1_leave && in_range && guard_on && last_axis) begin
            n_start_cnt = r_start_cnt + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_cnt <= 16'd0;
        end else begin
            r_start_cnt <= n_start_cnt;
        end
    end

    assign gsel = (r_item.axis > 3'(arpc_pkg::NUM_GAINS - 1)) ?
                  3'(arpc_pkg::NUM_GAINS - 1) : r_item.axis;

    assign vreq.diff = law.diff;
    assign vreq.gain = cfg.gain[gsel];
    assign vreq.res  = law.res;

    arpc_vel u_vel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s1_vld),
        .o_ready    (vel_rdy),
        .i_req      (vreq),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_axis     (o_out_axis),
        .o_velocity (o_velocity_command),
        .o_desired  (o_desired_out),
        .o_weight   (o_weight_out)
    );

    `ASSERT_IMPL(a_unknown_axis_zero, i_clk, i_rst_n,
        o_out_valid && (5'(o_out_axis) >= 5'(NUM_AXES)),
        (o_velocity_command == 32'sd0) && (o_desired_out == 32'sd0) && (o_weight_out == 17'd0))

    `ASSERT_NEXT(a_cnt_frozen_after_guard, i_clk, i_rst_n,
        !guard_on, r_start_cnt == $past(r_start_cnt))

    `ASSERT_IMPL(a_guard_holds_still, i_clk, i_rst_n,
        r_s1_vld && guard_on && in_range,
        (law.diff == 35'sd0) && law.wr && law.nxt.active)

endmodule

### sim/axis_range_position_controller_test.sv
`timescale 1ns / 100ps

module axis_range_position_controller_test;

    localparam int CLK_PERIOD = 4;
    localparam int NAX = arpc_pkg::NUM_AXES_DEF;
    localparam int PHASE_REQS = 112;
    localparam int QUIET_LIMIT = 1000;
    localparam logic [1:0] MODE_STOP = 2'd2;
    localparam logic [1:0] MODE_STOP_ALT = 2'd3;
    localparam logic [22:0] GAIN_MAX = 23'd4194304;

    typedef struct packed {
        logic [2:0]         axis;
        logic signed [31:0] vel;
        logic signed [31:0] desired;
        logic [16:0]        weight;
    } t_servo_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [arpc_pkg::APB_AW-1:0] paddr = '0;
    logic [arpc_pkg::APB_DW-1:0] pwdata = '0;
    logic [arpc_pkg::APB_DW-1:0] prdata;
    logic pready;

    logic i_in_valid = 1'b0;
    logic o_in_stall;
    arpc_pkg::t_item cur_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [2:0] o_out_axis;
    logic signed [31:0] o_velocity_command;
    logic signed [31:0] o_desired_out;
    logic [16:0] o_weight_out;

    // controller copy: settings and per-axis state
    logic [1:0] mode_c = arpc_pkg::MODE_SETPOINT;
    logic [15:0] guard_c = 16'(arpc_pkg::GUARD_RESET);
    logic [22:0] gain_c [arpc_pkg::NUM_GAINS] = '{default: 23'(arpc_pkg::ONE_Q16)};
    logic [22:0] plan_gain [arpc_pkg::NUM_GAINS] = '{default: 23'(arpc_pkg::ONE_Q16)};
    longint lo_r [NAX] = '{default: 0};
    longint hi_r [NAX] = '{default: 0};
    bit act_r [NAX] = '{default: 1'b0};
    longint des_r [NAX] = '{default: arpc_pkg::ONE_Q16};
    longint wgt_r [NAX] = '{default: arpc_pkg::ONE_Q16};
    logic [15:0] sweep_cnt = '0;

    arpc_pkg::t_item servo_req_q [$];
    t_servo_result servo_result_q [$];
    t_servo_result exp_res;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;
    int in_gap = 0;
    int in_calm = 0;
    int out_hold = 0;
    int out_calm = 0;

    axis_range_position_controller u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_axis             (cur_req.axis),
        .i_measured_value   (cur_req.measured_value),
        .i_set_range        (cur_req.set_range),
        .i_range_low        (cur_req.range_low),
        .i_range_high       (cur_req.range_high),
        .i_range_active     (cur_req.range_active),
        .i_set_desired      (cur_req.set_desired),
        .i_desired_command  (cur_req.desired_command),
        .i_set_weight       (cur_req.set_weight),
        .i_weight_cmd       (cur_req.weight_cmd),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_axis         (o_out_axis),
        .o_velocity_command (o_velocity_command),
        .o_desired_out      (o_desired_out),
        .o_weight_out       (o_weight_out)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // gain * error in Q16.16, floor rounding, saturated
    function automatic longint scale_vel(input longint g, input longint d);
        longint p;
        p = (g * d) >>> 16;
        return clamp32(p);
    endfunction

    function automatic t_servo_result servo_step(input arpc_pkg::t_item it);
        t_servo_result r;
        int ax;
        longint v, lo, hi, ss, vel, wl, wh, m;
        r = '0;
        r.axis = it.axis;
        vel = 0;
        if (it.axis >= NAX) begin
            return r;
        end
        ax = it.axis;
        v = longint'($signed(it.measured_value));
        if (it.set_range) begin
            lo_r[ax] = longint'($signed(it.range_low));
            hi_r[ax] = longint'($signed(it.range_high));
            act_r[ax] = it.range_active;
        end
        if (it.set_desired) begin
            des_r[ax] = longint'($signed(it.desired_command));
        end
        if (it.set_weight) begin
            wgt_r[ax] = (it.weight_cmd > 17'(arpc_pkg::ONE_Q16)) ?
                        longint'(arpc_pkg::ONE_Q16) : longint'(it.weight_cmd);
        end
        if (mode_c == arpc_pkg::MODE_SETPOINT) begin
            vel = scale_vel(longint'(gain_c[ax]), des_r[ax] - v);
        end else if (mode_c == arpc_pkg::MODE_RANGE && act_r[ax]) begin
            lo = lo_r[ax];
            hi = hi_r[ax];
            // narrow or inverted range shrinks by half its width
            ss = (hi - lo < 2 * arpc_pkg::RANGE_MARGIN) ? ((hi - lo) >>> 1)
                                                         : longint'(arpc_pkg::RANGE_MARGIN);
            if (v > hi - ss) begin
                vel = scale_vel(longint'(gain_c[ax]), hi - ss - v);
                des_r[ax] = clamp32(hi - ss);
            end else if (v < lo + ss) begin
                vel = scale_vel(longint'(gain_c[ax]), lo + ss - v);
                des_r[ax] = clamp32(lo + ss);
            end else begin
                vel = 0;
                des_r[ax] = v;
            end
            if (v > hi || v < lo) begin
                wgt_r[ax] = arpc_pkg::ONE_Q16;
            end else begin
                wl = arpc_pkg::RAMP_SLOPE * (v - hi) + arpc_pkg::ONE_Q16;
                wh = arpc_pkg::RAMP_SLOPE * (lo - v) + arpc_pkg::ONE_Q16;
                if (wl < 0) begin
                    wl = 0;
                end
                if (wh < 0) begin
                    wh = 0;
                end
                wgt_r[ax] = (wl > wh) ? wl : wh;
            end
        end
        if (sweep_cnt < guard_c) begin
            m = (ax < arpc_pkg::NUM_LIN_AXES) ? arpc_pkg::GUARD_MARGIN_LIN
                                              : arpc_pkg::GUARD_MARGIN_ANG;
            des_r[ax] = v;
            lo_r[ax] = clamp32(v - m);
            hi_r[ax] = clamp32(v + m);
            act_r[ax] = 1'b1;
            vel = 0;
            if (ax == NAX - 1) begin
                sweep_cnt = sweep_cnt + 16'd1;
            end
        end
        r.vel = vel[31:0];
        r.desired = des_r[ax][31:0];
        r.weight = wgt_r[ax][16:0];
        return r;
    endfunction

    // mostly short gaps, a few long ones, now and then a stretch with none
    function automatic int draw_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 2) begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] pick_val(input logic [31:0] c, input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return $urandom;
        end
        if (r < 12) begin
            return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
        end
        return c + 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic arpc_pkg::t_item rand_req();
        arpc_pkg::t_item it;
        int r;
        it = '0;
        r = $urandom_range(0, 99);
        it.axis = (r < 4) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        it.measured_value = pick_val(32'd0, 300000);
        it.set_range = ($urandom_range(0, 99) < 30);
        it.range_low = pick_val(it.measured_value, 40000);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            it.range_high = $urandom;
        end else if (r < 25) begin
            it.range_high = it.range_low - 32'($urandom_range(1, 5000));
        end else if (r < 45) begin
            it.range_high = it.range_low
                            + 32'($urandom_range(0, 2 * arpc_pkg::RANGE_MARGIN - 1));
        end else begin
            it.range_high = it.range_low
                            + 32'($urandom_range(2 * arpc_pkg::RANGE_MARGIN, 80000));
        end
        it.range_active = ($urandom_range(0, 99) < 85);
        it.set_desired = ($urandom_range(0, 99) < 30);
        it.desired_command = pick_val(it.measured_value, 100000);
        it.set_weight = ($urandom_range(0, 99) < 25);
        it.weight_cmd = ($urandom_range(0, 99) < 15) ? 17'($urandom_range(65537, 131071))
                                                      : 17'($urandom_range(0, arpc_pkg::ONE_Q16));
        return it;
    endfunction

    function automatic void add_req(input arpc_pkg::t_item it);
        servo_req_q.insert(servo_req_q.size(), it);
    endfunction

    task automatic apb_write(input arpc_pkg::t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= arpc_pkg::APB_AW'(4 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            arpc_pkg::REG_CONTROL_MODE: mode_c = val[1:0];
            arpc_pkg::REG_GUARD_CYCLES: guard_c = val[15:0];
            default: gain_c[int'(idx) - int'(arpc_pkg::REG_GAIN0)] = val[22:0];
        endcase
    endtask

    task automatic apply_settings(input logic [1:0] m, input logic [15:0] g);
        apb_write(arpc_pkg::REG_CONTROL_MODE, 32'(m));
        apb_write(arpc_pkg::REG_GUARD_CYCLES, 32'(g));
        for (int i = 0; i < arpc_pkg::NUM_GAINS; i++) begin
            apb_write(arpc_pkg::t_reg_idx'(int'(arpc_pkg::REG_GAIN0) + i), 32'(plan_gain[i]));
        end
    endtask

    task automatic drain();
        while (servo_req_q.size() != 0 || i_in_valid || servo_result_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                servo_result_q.insert(servo_result_q.size(), servo_step(cur_req));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (servo_req_q.size() != 0) begin
                    cur_req <= servo_req_q.pop_front();
                    i_in_valid <= 1'b1;
                    in_gap = draw_gap(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            out_hold = draw_gap(out_calm);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (servo_result_q.size() == 0) begin
                $error("result without request: axis %0d", o_out_axis);
                mismatch_cnt++;
            end else begin
                exp_res = servo_result_q.pop_front();
                if (o_out_axis !== exp_res.axis) begin
                    $error("out_axis: expected %0d, actual %0d", exp_res.axis, o_out_axis);
                    mismatch_cnt++;
                end
                if (o_velocity_command !== exp_res.vel) begin
                    $error("velocity_command: expected %0d, actual %0d",
                           exp_res.vel, o_velocity_command);
                    mismatch_cnt++;
                end
                if (o_desired_out !== exp_res.desired) begin
                    $error("desired_out: expected %0d, actual %0d",
                           exp_res.desired, o_desired_out);
                    mismatch_cnt++;
                end
                if (o_weight_out !== exp_res.weight) begin
                    $error("weight_out: expected %0d, actual %0d", exp_res.weight, o_weight_out);
                    mismatch_cnt++;
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [1:0] m;
        logic [15:0] g;
        int r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start-up hold with reset settings
        add_req(arpc_pkg::t_item'{3'd0, 32'sh7fffffff, 1'b1, -32'sd100, 32'sd100, 1'b1,
                                  1'b1, 32'sd5, 1'b1, 17'h1ffff});
        add_req(arpc_pkg::t_item'{3'd3, 32'sh80000000, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd1, 32'sd0, 1'b1, 32'sh80000000, 32'sh7fffffff, 1'b0,
                                  1'b1, 32'sh80000000, 1'b1, 17'd0});
        add_req(arpc_pkg::t_item'{3'd2, 32'sh00010000, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b0, 32'sd0, 1'b1, 17'd65536});
        add_req(arpc_pkg::t_item'{3'd4, -32'sd5000, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b1, 32'sh7fffffff, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd5, 32'sd1234, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd6, 32'sh7fffffff, 1'b1, 32'sd1, 32'sd2, 1'b1,
                                  1'b1, 32'sd3, 1'b1, 17'd4});
        add_req(arpc_pkg::t_item'{3'd7, 32'sh80000000, 1'b1, 32'sh7fffffff, 32'sh80000000,
                                  1'b1, 1'b1, -32'sd1, 1'b1, 17'h1ffff});
        drain();

        // setpoint mode, saturation and rounding
        plan_gain = '{GAIN_MAX, 23'd0, 23'h7fffff, 23'(arpc_pkg::ONE_Q16), 23'd1, 23'd32768};
        apply_settings(arpc_pkg::MODE_SETPOINT, 16'd0);
        add_req(arpc_pkg::t_item'{3'd0, 32'sh80000000, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b1, 32'sh7fffffff, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd2, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b1, 32'sh80000000, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd1, 32'sd77, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b1, 32'sh40000000, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd4, 32'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b1, -32'sd1, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd5, 32'sd3, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b1, 32'sd0, 1'b0, 17'd0});
        drain();

        // range mode: above, below, deep inside, near edge, narrow, inverted, inactive
        plan_gain = '{default: 23'(arpc_pkg::ONE_Q16)};
        apply_settings(arpc_pkg::MODE_RANGE, 16'd0);
        add_req(arpc_pkg::t_item'{3'd0, 32'sd131072, 1'b1, 32'sd0, 32'sd65536, 1'b1,
                                  1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd0, -32'sd1000, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd0, 32'sd32768, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd0, 32'sd1000, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd1, 32'sd5000, 1'b1, 32'sd100, 32'sd3000, 1'b1,
                                  1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd2, 32'sd0, 1'b1, 32'sd1000, -32'sd1000, 1'b1,
                                  1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd3, 32'sd5, 1'b1, 32'sd0, 32'sd100000, 1'b0,
                                  1'b1, 32'sd9, 1'b1, 17'd1});
        add_req(arpc_pkg::t_item'{3'd4, 32'sh80000000, 1'b1, 32'sh80000000, 32'sh7fffffff,
                                  1'b1, 1'b0, 32'sd0, 1'b0, 17'd0});
        add_req(arpc_pkg::t_item'{3'd5, 32'sd42, 1'b1, 32'sd0, 32'sd10, 1'b0,
                                  1'b0, 32'sd0, 1'b1, 17'h1ffff});
        drain();

        // stop modes
        apb_write(arpc_pkg::REG_CONTROL_MODE, 32'(MODE_STOP));
        add_req(arpc_pkg::t_item'{3'd0, 32'sd77, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b1, 32'sd500, 1'b0, 17'd0});
        drain();
        apb_write(arpc_pkg::REG_CONTROL_MODE, 32'(MODE_STOP_ALT));
        add_req(arpc_pkg::t_item'{3'd1, -32'sd77, 1'b0, 32'sd0, 32'sd0, 1'b0,
                                  1'b0, 32'sd0, 1'b1, 17'd300});
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                m = arpc_pkg::MODE_RANGE;
            end else if (r < 8) begin
                m = arpc_pkg::MODE_SETPOINT;
            end else begin
                m = 2'($urandom_range(MODE_STOP, MODE_STOP_ALT));
            end
            if (ph == 2) begin
                g = 16'hffff;
            end else if (ph == 5) begin
                // hold ends part way through the phase
                g = sweep_cnt + 16'd4;
            end else begin
                g = 16'd0;
            end
            for (int i = 0; i < arpc_pkg::NUM_GAINS; i++) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    plan_gain[i] = 23'd0;
                end else if (r == 1) begin
                    plan_gain[i] = GAIN_MAX;
                end else if (r == 2) begin
                    plan_gain[i] = 23'($urandom);
                end else begin
                    plan_gain[i] = 23'($urandom_range(0, 4 * arpc_pkg::ONE_Q16));
                end
            end
            apply_settings(m, g);
            for (int k = 0; k < PHASE_REQS; k++) begin
                add_req(rand_req());
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (servo_result_q.size() != 0) begin
            $error("%0d results never arrived", servo_result_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
